>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLBE_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RLBE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rlbe_pkg.sv
// ----------------------------------------------------------------------------
// Run/literal byte encoder package
// Types and constants shared by the front end, back end and packer.
// ----------------------------------------------------------------------------
package rlbe_pkg;

  localparam logic [7:0] RUN_MIN      = 8'd3;
  localparam logic [7:0] RUN_MAX      = 8'd130;
  localparam logic [7:0] RUN_HDR_BASE = 8'h80;
  localparam int unsigned CMD_DEPTH   = 4;
  localparam int unsigned RES_DEPTH   = 2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_SPILL,
    OP_RUN
  } op_kind_e;

  typedef enum logic [1:0] {
    STG_A,
    STG_B,
    STG_F,
    STG_E
  } stage_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_APPEND,
    ST_LIT_HDR,
    ST_LIT_DATA,
    ST_RUN_HDR,
    ST_RUN_VAL,
    ST_END
  } back_state_e;

  typedef struct packed {
    op_kind_e    a_kind;
    logic [7:0]  a_val;
    logic [7:0]  a_len;
    op_kind_e    b_kind;
    logic [7:0]  b_val;
    logic [7:0]  b_len;
    logic        fin;
  } cmd_t;

  typedef struct packed {
    logic        dat_vld;
    logic [7:0]  dat;
    logic        end_vld;
    logic        fin;
  } pack_req_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            item_done;
    logic            stream_done;
  } res_t;

endpackage

>>> rtl/rlbe_fifo.sv
// ----------------------------------------------------------------------------
// Word queue
// Small synchronous first-in first-out queue used between the stages.
// ----------------------------------------------------------------------------
module rlbe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign wr_en     = wr_i && !full_o;
  assign rd_en     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> rtl/rlbe_front.sv
// ----------------------------------------------------------------------------
// Encoder front end
// Tracks the open group of equal bytes and turns each input byte into one
// command for the back end.
// ----------------------------------------------------------------------------
module rlbe_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [7:0]      data_byte_i,
  input  logic            final_byte_i,
  input  logic            cmd_full_i,
  output logic            cmd_push_o,
  output rlbe_pkg::cmd_t  cmd_o
);

  import rlbe_pkg::*;

  logic [7:0] grp_val_q, grp_val_d;
  logic [7:0] grp_len_q, grp_len_d;
  logic [7:0] len1, len2, val2;
  logic       accept;

  assign accept     = push_i && !cmd_full_i;
  assign cmd_push_o = accept;

  always_comb begin
    cmd_o      = '0;
    cmd_o.fin  = final_byte_i;
    len1       = grp_len_q;
    if (grp_len_q != 8'd0 && data_byte_i != grp_val_q) begin
      cmd_o.a_kind = (grp_len_q >= RUN_MIN) ? OP_RUN : OP_SPILL;
      cmd_o.a_val  = grp_val_q;
      cmd_o.a_len  = grp_len_q;
      len1         = 8'd0;
    end
    if (len1 == 8'd0) begin
      val2 = data_byte_i;
      len2 = 8'd1;
    end else begin
      val2 = grp_val_q;
      len2 = len1 + 8'd1;
    end
    grp_val_d = val2;
    grp_len_d = len2;
    if (len2 == RUN_MAX) begin
      cmd_o.b_kind = OP_RUN;
      cmd_o.b_val  = val2;
      cmd_o.b_len  = len2;
      grp_len_d    = 8'd0;
    end else if (final_byte_i) begin
      cmd_o.b_kind = (len2 >= RUN_MIN) ? OP_RUN : OP_SPILL;
      cmd_o.b_val  = val2;
      cmd_o.b_len  = len2;
    end
    if (final_byte_i) begin
      grp_val_d = 8'd0;
      grp_len_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_val_q <= 8'd0;
      grp_len_q <= 8'd0;
    end else if (accept) begin
      grp_val_q <= grp_val_d;
      grp_len_q <= grp_len_d;
    end
  end

endmodule

>>> rtl/rlbe_back.sv
// ----------------------------------------------------------------------------
// Encoder back end
// Executes commands: appends literals to the literal store, flushes literal
// and run chunks, one compressed byte per cycle while the packer is ready.
// ----------------------------------------------------------------------------
module rlbe_back #(
  parameter int unsigned LITERAL_MAX = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_empty_i,
  input  rlbe_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output rlbe_pkg::pack_req_t pack_req_o,
  input  logic                pack_rdy_i
);

  import rlbe_pkg::*;

  localparam int unsigned AW = (LITERAL_MAX > 1) ? $clog2(LITERAL_MAX) : 1;
  localparam int unsigned CW = $clog2(LITERAL_MAX + 1);

  back_state_e   state_q, state_d;
  stage_e        stg_q, stg_d, stg_nxt;
  cmd_t          cmd_q, cmd_d;
  logic [7:0]    op_val_q, op_val_d;
  logic [7:0]    op_len_q, op_len_d;
  logic [1:0]    rem_q, rem_d;
  logic          run_pend_q, run_pend_d;
  logic [CW-1:0] lit_cnt_q, lit_cnt_d;
  logic [CW-1:0] rd_ptr_q, rd_ptr_d;
  logic [7:0]    rd_data_q;
  logic [7:0]    mem_q [LITERAL_MAX];
  logic          mem_we;
  op_kind_e      sel_kind;
  logic [7:0]    sel_val, sel_len;
  back_state_e   ret_state;
  stage_e        ret_stg;

  assign sel_kind = (stg_q == STG_A) ? cmd_q.a_kind : cmd_q.b_kind;
  assign sel_val  = (stg_q == STG_A) ? cmd_q.a_val  : cmd_q.b_val;
  assign sel_len  = (stg_q == STG_A) ? cmd_q.a_len  : cmd_q.b_len;

  always_comb begin
    unique case (stg_q)
      STG_A:   stg_nxt = STG_B;
      STG_B:   stg_nxt = STG_F;
      STG_F:   stg_nxt = STG_E;
      STG_E:   stg_nxt = STG_E;
      default: stg_nxt = STG_E;
    endcase
  end

  // Where to continue once a literal chunk has gone out.
  always_comb begin
    ret_stg = stg_q;
    priority if (run_pend_q) begin
      ret_state = ST_RUN_HDR;
    end else if (rem_q != 2'd0) begin
      ret_state = ST_APPEND;
    end else begin
      ret_state = ST_DISPATCH;
      ret_stg   = stg_nxt;
    end
  end

  always_comb begin
    state_d    = state_q;
    stg_d      = stg_q;
    cmd_d      = cmd_q;
    op_val_d   = op_val_q;
    op_len_d   = op_len_q;
    rem_d      = rem_q;
    run_pend_d = run_pend_q;
    lit_cnt_d  = lit_cnt_q;
    rd_ptr_d   = rd_ptr_q;
    mem_we     = 1'b0;
    cmd_pop_o  = 1'b0;
    pack_req_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          stg_d     = STG_A;
          state_d   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (stg_q)
          STG_A, STG_B: begin
            unique case (sel_kind)
              OP_SPILL: begin
                op_val_d = sel_val;
                rem_d    = sel_len[1:0];
                state_d  = ST_APPEND;
              end
              OP_RUN: begin
                op_val_d   = sel_val;
                op_len_d   = sel_len;
                run_pend_d = 1'b1;
                state_d    = (lit_cnt_q != '0) ? ST_LIT_HDR : ST_RUN_HDR;
              end
              default: begin
                stg_d = stg_nxt;
              end
            endcase
          end
          STG_F: begin
            if (cmd_q.fin && lit_cnt_q != '0) begin
              state_d = ST_LIT_HDR;
            end else begin
              stg_d = STG_E;
            end
          end
          default: begin
            state_d = ST_END;
          end
        endcase
      end
      ST_APPEND: begin
        mem_we    = 1'b1;
        lit_cnt_d = lit_cnt_q + CW'(1);
        rem_d     = rem_q - 2'd1;
        if (lit_cnt_q == CW'(LITERAL_MAX - 1)) begin
          state_d = ST_LIT_HDR;
        end else if (rem_q == 2'd1) begin
          stg_d   = stg_nxt;
          state_d = ST_DISPATCH;
        end
      end
      ST_LIT_HDR: begin
        pack_req_o.dat_vld = 1'b1;
        pack_req_o.dat     = 8'(lit_cnt_q - CW'(1));
        rd_ptr_d           = '0;
        if (pack_rdy_i) begin
          state_d = ST_LIT_DATA;
        end
      end
      ST_LIT_DATA: begin
        pack_req_o.dat_vld = 1'b1;
        pack_req_o.dat     = rd_data_q;
        if (pack_rdy_i) begin
          rd_ptr_d = rd_ptr_q + CW'(1);
          if (rd_ptr_q + CW'(1) == lit_cnt_q) begin
            lit_cnt_d = '0;
            state_d   = ret_state;
            stg_d     = ret_stg;
          end
        end
      end
      ST_RUN_HDR: begin
        pack_req_o.dat_vld = 1'b1;
        pack_req_o.dat     = RUN_HDR_BASE + op_len_q - RUN_MIN;
        if (pack_rdy_i) begin
          state_d = ST_RUN_VAL;
        end
      end
      ST_RUN_VAL: begin
        pack_req_o.dat_vld = 1'b1;
        pack_req_o.dat     = op_val_q;
        if (pack_rdy_i) begin
          run_pend_d = 1'b0;
          stg_d      = stg_nxt;
          state_d    = ST_DISPATCH;
        end
      end
      ST_END: begin
        pack_req_o.end_vld = 1'b1;
        pack_req_o.fin     = cmd_q.fin;
        if (pack_rdy_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      stg_q      <= STG_A;
      rem_q      <= 2'd0;
      run_pend_q <= 1'b0;
      lit_cnt_q  <= '0;
      rd_ptr_q   <= '0;
    end else begin
      state_q    <= state_d;
      stg_q      <= stg_d;
      rem_q      <= rem_d;
      run_pend_q <= run_pend_d;
      lit_cnt_q  <= lit_cnt_d;
      rd_ptr_q   <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    op_val_q <= op_val_d;
    op_len_q <= op_len_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[lit_cnt_q[AW-1:0]] <= op_val_q;
    end
    rd_data_q <= mem_q[rd_ptr_d[AW-1:0]];
  end

endmodule

>>> rtl/rlbe_pack.sv
// ----------------------------------------------------------------------------
// Output packer
// Gathers compressed bytes into words of up to four bytes and closes a word
// at the end of each input byte's output.
// ----------------------------------------------------------------------------
module rlbe_pack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rlbe_pkg::pack_req_t req_i,
  output logic                rdy_o,
  output logic                res_push_o,
  output rlbe_pkg::res_t      res_o,
  input  logic                res_full_i
);

  import rlbe_pkg::*;

  logic [3:0][7:0] word_q, word_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            need_push;

  assign need_push = (req_i.dat_vld && cnt_q == 3'd4) || (req_i.end_vld && cnt_q != 3'd0);
  assign rdy_o      = !need_push || !res_full_i;
  assign res_push_o = need_push && !res_full_i;

  always_comb begin
    res_o.bytes       = word_q;
    res_o.count       = cnt_q;
    res_o.item_done   = req_i.end_vld;
    res_o.stream_done = req_i.end_vld && req_i.fin;
  end

  always_comb begin
    word_d = word_q;
    cnt_d  = cnt_q;
    if (rdy_o) begin
      if (req_i.dat_vld) begin
        if (cnt_q == 3'd4 || cnt_q == 3'd0) begin
          word_d    = '0;
          word_d[0] = req_i.dat;
          cnt_d     = 3'd1;
        end else begin
          word_d[cnt_q[1:0]] = req_i.dat;
          cnt_d              = cnt_q + 3'd1;
        end
      end else if (req_i.end_vld) begin
        cnt_d = 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

>>> rtl/run_literal_byte_encoder.sv
// ----------------------------------------------------------------------------
// Run/literal byte encoder
// Compresses a byte stream into run and literal chunks, packed up to four
// bytes per output word.
// ----------------------------------------------------------------------------
//  channel   handshake          word
//  input     push / full        data_byte_i, final_byte_i
//  output    empty / pop        out_byte0_o..out_byte3_o, out_count_o,
//                               item_done_o, stream_done_o
//
// The front end takes one byte per cycle into a four-entry command queue,
// while the queue is not full. The back end takes one command at a time,
// writes each literal to the store and sends each compressed byte on.
// The literal store is not cleared at reset; only written entries are read.
// Either side may stall at any time without loss.
// ----------------------------------------------------------------------------
module run_literal_byte_encoder #(
  parameter int unsigned LITERAL_MAX = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte0_o,
  output logic [7:0] out_byte1_o,
  output logic [7:0] out_byte2_o,
  output logic [7:0] out_byte3_o,
  output logic [2:0] out_count_o,
  output logic       item_done_o,
  output logic       stream_done_o
);

  import rlbe_pkg::*;

  cmd_t      front_cmd, back_cmd;
  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  pack_req_t pack_req;
  logic      pack_rdy;
  res_t      pack_res, out_res;
  logic      res_push, res_full;

  rlbe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .cmd_full_i   (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (front_cmd)
  );

  rlbe_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_push),
    .wr_data_i (front_cmd),
    .full_o    (cmd_full),
    .rd_i      (cmd_pop),
    .rd_data_o (back_cmd),
    .empty_o   (cmd_empty)
  );

  rlbe_back #(
    .LITERAL_MAX (LITERAL_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .pack_req_o  (pack_req),
    .pack_rdy_i  (pack_rdy)
  );

  rlbe_pack u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (pack_req),
    .rdy_o      (pack_rdy),
    .res_push_o (res_push),
    .res_o      (pack_res),
    .res_full_i (res_full)
  );

  rlbe_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_push),
    .wr_data_i (pack_res),
    .full_o    (res_full),
    .rd_i      (pop),
    .rd_data_o (out_res),
    .empty_o   (empty)
  );

  assign full          = cmd_full;
  assign out_byte0_o   = out_res.bytes[0];
  assign out_byte1_o   = out_res.bytes[1];
  assign out_byte2_o   = out_res.bytes[2];
  assign out_byte3_o   = out_res.bytes[3];
  assign out_count_o   = out_res.count;
  assign item_done_o   = out_res.item_done;
  assign stream_done_o = out_res.stream_done;

endmodule

>>> rtl/rlbe_checker.sv
// ----------------------------------------------------------------------------
// Encoder port checker
// Watches the ports of the run/literal byte encoder for malformed words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlbe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte0_o,
  input logic [7:0] out_byte1_o,
  input logic [7:0] out_byte2_o,
  input logic [7:0] out_byte3_o,
  input logic [2:0] out_count_o,
  input logic       item_done_o,
  input logic       stream_done_o
);

  `RLBE_ASSERT_IMPL(a_count_range, clk_i, rst_ni, !empty, out_count_o == 3'd1 || out_count_o == 3'd2 || out_count_o == 3'd3 || out_count_o == 3'd4, "word byte count out of range")

  `RLBE_ASSERT_IMPL(a_stream_ends_item, clk_i, rst_ni, !empty && stream_done_o, item_done_o, "stream end without item end")

  `RLBE_ASSERT_IMPL(a_unused_zero, clk_i, rst_ni, !empty, (out_count_o >= 3'd2 || out_byte1_o == 8'd0) && (out_count_o >= 3'd3 || out_byte2_o == 8'd0) && (out_count_o == 3'd4 || out_byte3_o == 8'd0), "unused word byte not zero")

  `RLBE_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_byte0_o) && $stable(out_count_o) && $stable(item_done_o) && $stable(stream_done_o), "waiting word changed")

endmodule

bind run_literal_byte_encoder rlbe_checker u_rlbe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .out_byte0_o   (out_byte0_o),
  .out_byte1_o   (out_byte1_o),
  .out_byte2_o   (out_byte2_o),
  .out_byte3_o   (out_byte3_o),
  .out_count_o   (out_count_o),
  .item_done_o   (item_done_o),
  .stream_done_o (stream_done_o)
);
